// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file lud_checker.sv.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/lud_pkg.sv =====
// Package for the LU decomposition unit: sizes, Q16.16 constants, sequencer states,
// store addressing and saturation helpers. No dependencies.
`default_nettype none
package lud_pkg;
	localparam int MAX_SIZE = 8;
	localparam logic [31:0] Q_ONE = 32'h0001_0000;
	localparam logic [31:0] Q_ZERO = 32'h0000_0000;
	localparam logic [31:0] Q_MAXV = 32'h7fff_ffff;
	localparam logic [31:0] Q_MINV = 32'h8000_0000;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SETUP,
		S_RD_IK,
		S_RD_KJ,
		S_MUL,
		S_ACC,
		S_RD_IJ,
		S_SUB,
		S_PIV,
		S_DIV,
		S_DIVEND,
		S_NEXT,
		S_EMIT,
		S_DRAIN
	} lud_state_t;

	function automatic logic [5:0] lud_addr(logic [2:0] r, logic [2:0] c, logic [3:0] n);
		logic [6:0] t;
		t = 7'(r) * 7'(n) + 7'(c);
		return t[5:0];
	endfunction

	function automatic logic sat_ovf(logic [47:0] v);
		return !((&v[47:31]) || !(|v[47:31]));
	endfunction

	function automatic logic [31:0] sat32(logic [47:0] v);
		logic [31:0] r;
		if (sat_ovf(v)) begin
			r = v[47] ? Q_MINV : Q_MAXV;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/lu_decomposition_unit.sv =====
// Doolittle LU factorization unit, Q16.16, with a shared multiplier and divider.
// Depends on lud_pkg.
`default_nettype none
// Elements of A are loaded one per cycle (start high, busy low) in row-major order. After the
// last one, busy rises while the matrix is factorized in place: each multiply-accumulate runs
// through RD_IK, RD_KJ, MUL and ACC on the single multiplier and store read port, each L entry
// adds a bit-serial divide of 48 quotient bits, plus setup and write-back steps per entry. Then
// n*n results leave one per cycle, each valid for a single cycle on result_valid; the receiver
// cannot stall them. The last result shows in the first cycle after busy falls.
module lu_decomposition_unit import lud_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] a_value,
	input  wire logic        matrix_size_we,
	input  wire logic [3:0]  matrix_size,
	output logic             result_valid,
	output logic [2:0]       row_index,
	output logic [2:0]       col_index,
	output logic [31:0]      l_value,
	output logic [31:0]      u_value,
	output logic             zero_pivot,
	output logic             overflow,
	output logic             last_result
);
	lud_state_t state_q, state_d;
	logic [3:0]  size_q;
	logic [3:0]  n;
	logic [6:0]  total;
	logic [6:0]  load_count_q;
	logic        pz_q, ov_q;
	logic [2:0]  i_q, j_q, k_q, lim;
	logic        upper;
	logic [35:0] acc_q;
	logic [31:0] opa_q, x_q;
	logic signed [63:0] prod_q;
	logic [31:0] rem_q, dvs_q;
	logic [47:0] dvd_q;
	logic        neg_q;
	logic [5:0]  dcnt_q;
	logic [2:0]  er_q, ec_q;
	logic [5:0]  eaddr_q;
	logic        valid_s1, last_s1;
	logic [2:0]  r_s1, c_s1;
	logic [31:0] mem [64];
	logic [31:0] rdata_q;
	logic        mem_we;
	logic [5:0]  mem_waddr, mem_raddr;
	logic [31:0] mem_wdata;
	logic [47:0] prod_t, sub_t;
	logic [31:0] prod_sat, sub_sat, x_mag, qsat;
	logic        q_ovf;
	logic [32:0] rs;
	logic        qbit;
	logic [31:0] rnext;

	assign n = (size_q == 4'd0) ? 4'd1 : ((size_q > 4'(MAX_SIZE)) ? 4'(MAX_SIZE) : size_q);
	assign total = 7'(n) * 7'(n);
	assign busy = (state_q != S_IDLE);
	assign upper = (i_q <= j_q);
	assign lim = upper ? i_q : j_q;

	assign prod_t = prod_q[63:16];
	assign prod_sat = sat32(prod_t);
	assign sub_t = {{16{rdata_q[31]}}, rdata_q} - {{12{acc_q[35]}}, acc_q};
	assign sub_sat = sat32(sub_t);
	assign x_mag = x_q[31] ? (~x_q + 32'd1) : x_q;

	assign rs = {rem_q, dvd_q[47]};
	assign qbit = (rs >= {1'b0, dvs_q});
	assign rnext = qbit ? 32'(rs - {1'b0, dvs_q}) : rs[31:0];

	always_comb begin
		q_ovf = 1'b0;
		if (neg_q) begin
			if (dvd_q > 48'h8000_0000) begin
				q_ovf = 1'b1;
				qsat = Q_MINV;
			end else begin
				qsat = ~dvd_q[31:0] + 32'd1;
			end
		end else begin
			if (dvd_q > 48'h7fff_ffff) begin
				q_ovf = 1'b1;
				qsat = Q_MAXV;
			end else begin
				qsat = dvd_q[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mem_we = 1'b0;
		mem_waddr = lud_addr(i_q, j_q, n);
		mem_wdata = a_value;
		mem_raddr = 6'd0;
		case (state_q)
			S_IDLE: begin
				mem_waddr = load_count_q[5:0];
				if (start && !matrix_size_we) begin
					mem_we = 1'b1;
					if (load_count_q + 7'd1 >= total) begin
						state_d = S_SETUP;
					end
				end
			end
			S_SETUP: state_d = (lim == 3'd0) ? S_RD_IJ : S_RD_IK;
			S_RD_IK: begin
				mem_raddr = lud_addr(i_q, k_q, n);
				state_d = S_RD_KJ;
			end
			S_RD_KJ: begin
				mem_raddr = lud_addr(k_q, j_q, n);
				state_d = S_MUL;
			end
			S_MUL: state_d = S_ACC;
			S_ACC: state_d = (k_q + 3'd1 == lim) ? S_RD_IJ : S_RD_IK;
			S_RD_IJ: begin
				mem_raddr = lud_addr(i_q, j_q, n);
				state_d = S_SUB;
			end
			S_SUB: begin
				mem_raddr = lud_addr(j_q, j_q, n);
				if (upper) begin
					mem_we = 1'b1;
					mem_wdata = sub_sat;
					state_d = S_NEXT;
				end else begin
					state_d = S_PIV;
				end
			end
			S_PIV: begin
				if (rdata_q == Q_ZERO) begin
					mem_we = 1'b1;
					mem_wdata = Q_ZERO;
					state_d = S_NEXT;
				end else begin
					state_d = S_DIV;
				end
			end
			S_DIV: if (dcnt_q == 6'd0) state_d = S_DIVEND;
			S_DIVEND: begin
				mem_we = 1'b1;
				mem_wdata = qsat;
				state_d = S_NEXT;
			end
			S_NEXT: begin
				if (4'(i_q) + 4'd1 < n) begin
					state_d = S_SETUP;
				end else if (4'(j_q) + 4'd1 < n) begin
					state_d = S_SETUP;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				mem_raddr = eaddr_q;
				if (7'(eaddr_q) + 7'd1 == total) state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[mem_raddr];
	end

	// control: load count, flags, size, emit strobes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 4'd8;
			load_count_q <= 7'd0;
			pz_q <= 1'b0;
			ov_q <= 1'b0;
			valid_s1 <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			valid_s1 <= (state_q == S_EMIT);
			result_valid <= valid_s1;
			if (matrix_size_we) begin
				size_q <= matrix_size;
				load_count_q <= 7'd0;
				pz_q <= 1'b0;
				ov_q <= 1'b0;
			end else begin
				case (state_q)
					S_IDLE: if (start) load_count_q <= load_count_q + 7'd1;
					S_ACC: if (sat_ovf(prod_t)) ov_q <= 1'b1;
					S_SUB: begin
						if (sat_ovf(sub_t)) ov_q <= 1'b1;
						if (upper && (i_q == j_q) && (sub_sat == Q_ZERO)) pz_q <= 1'b1;
					end
					S_PIV: if (rdata_q == Q_ZERO) pz_q <= 1'b1;
					S_DIVEND: if (q_ovf) ov_q <= 1'b1;
					S_DRAIN: begin
						load_count_q <= 7'd0;
						pz_q <= 1'b0;
						ov_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				i_q <= 3'd0;
				j_q <= 3'd0;
			end
			S_SETUP: begin
				acc_q <= 36'd0;
				k_q <= 3'd0;
			end
			S_RD_KJ: opa_q <= rdata_q;
			S_MUL: prod_q <= $signed(opa_q) * $signed(rdata_q);
			S_ACC: begin
				acc_q <= acc_q + {{4{prod_sat[31]}}, prod_sat};
				k_q <= k_q + 3'd1;
			end
			S_SUB: x_q <= sub_sat;
			S_PIV: begin
				rem_q <= 32'd0;
				dvd_q <= {x_mag, 16'd0};
				dvs_q <= rdata_q[31] ? (~rdata_q + 32'd1) : rdata_q;
				neg_q <= x_q[31] ^ rdata_q[31];
				dcnt_q <= 6'd47;
			end
			S_DIV: begin
				rem_q <= rnext;
				dvd_q <= {dvd_q[46:0], qbit};
				dcnt_q <= dcnt_q - 6'd1;
			end
			S_NEXT: begin
				if (4'(i_q) + 4'd1 < n) begin
					i_q <= i_q + 3'd1;
				end else begin
					i_q <= 3'd0;
					j_q <= j_q + 3'd1;
				end
				er_q <= 3'd0;
				ec_q <= 3'd0;
				eaddr_q <= 6'd0;
			end
			S_EMIT: begin
				r_s1 <= er_q;
				c_s1 <= ec_q;
				last_s1 <= (7'(eaddr_q) + 7'd1 == total);
				eaddr_q <= eaddr_q + 6'd1;
				if (4'(ec_q) + 4'd1 == n) begin
					ec_q <= 3'd0;
					er_q <= er_q + 3'd1;
				end else begin
					ec_q <= ec_q + 3'd1;
				end
			end
			default: ;
		endcase
	end

	// output beat
	always_ff @(posedge clk) begin
		row_index <= r_s1;
		col_index <= c_s1;
		zero_pivot <= pz_q;
		overflow <= ov_q;
		last_result <= last_s1 && valid_s1;
		if (r_s1 > c_s1) begin
			l_value <= rdata_q;
			u_value <= Q_ZERO;
		end else if (r_s1 == c_s1) begin
			l_value <= Q_ONE;
			u_value <= rdata_q;
		end else begin
			l_value <= Q_ZERO;
			u_value <= rdata_q;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/lud_checker.sv =====
// Port-level checker for lu_decomposition_unit, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lud_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        busy,
	input wire logic        result_valid,
	input wire logic [2:0]  row_index,
	input wire logic [2:0]  col_index,
	input wire logic [31:0] l_value,
	input wire logic [31:0] u_value,
	input wire logic        last_result
);
	`CHK_IMPL(a_last_beat, last_result, result_valid)
	`CHK_IMPL(a_mid_busy, result_valid && !last_result, busy)
	`CHK_NEXT(a_last_alone, result_valid && last_result, !result_valid)
	`CHK_IMPL(a_diag_one, result_valid && (row_index == col_index), l_value == 32'h0001_0000)
	`CHK_IMPL(a_tri, result_valid && (row_index > col_index), u_value == 32'd0)
endmodule

bind lu_decomposition_unit lud_checker u_lud_checker (
	.clk(clk),
	.arst_n(arst_n),
	.busy(busy),
	.result_valid(result_valid),
	.row_index(row_index),
	.col_index(col_index),
	.l_value(l_value),
	.u_value(u_value),
	.last_result(last_result)
);
`default_nettype wire
